### design/pgwalk_pkg.sv
// Shared types and constants for the four-level page-table walker.
// No dependencies; every other design file refers to it by scoped names.
package pgwalk_pkg;

  // Field widths fixed by the page-table format
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int ENTRY_W = 64;
  localparam int WIDX_W  = 12;
  localparam int BASE_W  = 40;   // table address bits 51:12
  localparam int IDX_W   = 9;    // index bits per table level (512 entries)
  localparam int WORD_W  = BASE_W + IDX_W;  // store word number of an entry

  // Entry bit positions
  localparam int BIT_PRESENT = 0;
  localparam int BIT_USER    = 2;
  localparam int BIT_SIZE    = 7;

  // Item opcodes
  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  // Fault kinds
  localparam logic [1:0] FAULT_NONE        = 2'd0;
  localparam logic [1:0] FAULT_NOT_PRESENT = 2'd1;
  localparam logic [1:0] FAULT_NOT_USER    = 2'd2;
  localparam logic [1:0] FAULT_OUTSIDE     = 2'd3;

  // Page size codes
  localparam logic [1:0] PAGE_4K = 2'd0;
  localparam logic [1:0] PAGE_2M = 2'd1;
  localparam logic [1:0] PAGE_1G = 2'd2;

  // Walk levels
  localparam logic [1:0] LEVEL_TOP  = 2'd0;
  localparam logic [1:0] LEVEL_1G   = 2'd1;
  localparam logic [1:0] LEVEL_2M   = 2'd2;
  localparam logic [1:0] LEVEL_LEAF = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK
  } walk_state_t;

  typedef struct packed {
    logic                mapped;
    logic [PA_W-1:0]     physical_address;
    logic [1:0]          page_size_code;
    logic [ENTRY_W-1:0]  leaf_entry;
    logic [1:0]          fault_kind;
    logic [1:0]          fault_level;
  } walk_result_t;

endpackage

### design/pgwalk_ifs.sv
// Handshake channels of the page-table walker: request, response, root write.
// Depends on pgwalk_pkg for field widths.
interface pgwalk_req_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [pgwalk_pkg::WIDX_W-1:0]    word_index;
  logic [pgwalk_pkg::ENTRY_W-1:0]   entry_value;
  logic [pgwalk_pkg::VA_W-1:0]      virtual_address;

  modport source (output valid, opcode, word_index, entry_value, virtual_address,
                  input ready);
  modport sink (input valid, opcode, word_index, entry_value, virtual_address,
                output ready);
endinterface

interface pgwalk_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             mapped;
  logic [pgwalk_pkg::PA_W-1:0]      physical_address;
  logic [1:0]                       page_size_code;
  logic [pgwalk_pkg::ENTRY_W-1:0]   leaf_entry;
  logic [1:0]                       fault_kind;
  logic [1:0]                       fault_level;

  modport source (output valid, mapped, physical_address, page_size_code, leaf_entry,
                  fault_kind, fault_level, input ready);
  modport sink (input valid, mapped, physical_address, page_size_code, leaf_entry,
                fault_kind, fault_level, output ready);
endinterface

interface pgwalk_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pgwalk_pkg::PA_W-1:0]      root_table_address;

  modport source (output valid, root_table_address, input ready);
  modport sink (input valid, root_table_address, output ready);
endinterface

### design/pgwalk_store.sv
// Table word store: one write port, one registered read port, clear sweep.
// Depends on pgwalk_pkg for the entry width.
module pgwalk_store #(
  parameter int TABLE_WORDS = 4096,
  localparam int AW = $clog2(TABLE_WORDS)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [pgwalk_pkg::ENTRY_W-1:0] wr_data,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [pgwalk_pkg::ENTRY_W-1:0] rd_data,
  output logic                           clearing
);

  logic [pgwalk_pkg::ENTRY_W-1:0] mem [TABLE_WORDS];
  logic [AW-1:0]                  clr_addr;

  // Sweep zeros through every word after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(TABLE_WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/pgwalk_walker.sv
// Walk sequencer: takes request words, writes table words, walks four levels.
// Depends on pgwalk_pkg and pgwalk_req_if; drives pgwalk_store's ports.
module pgwalk_walker #(
  parameter int TABLE_WORDS = 4096,
  localparam int AW = $clog2(TABLE_WORDS)
) (
  input  logic                           clk,
  input  logic                           rst,
  pgwalk_req_if.sink                     req,
  input  logic [pgwalk_pkg::PA_W-1:0]    root,
  input  logic                           clearing,
  output logic                           wr_en,
  output logic [AW-1:0]                  wr_addr,
  output logic [pgwalk_pkg::ENTRY_W-1:0] wr_data,
  output logic                           rd_en,
  output logic [AW-1:0]                  rd_addr,
  input  logic [pgwalk_pkg::ENTRY_W-1:0] rd_data,
  output logic                           res_valid,
  input  logic                           res_ready,
  output pgwalk_pkg::walk_result_t       res
);

  pgwalk_pkg::walk_state_t            state;
  pgwalk_pkg::walk_state_t            state_next;
  logic [1:0]                         level;
  logic [pgwalk_pkg::BASE_W-1:0]      table_base;
  logic [pgwalk_pkg::VA_W-1:0]        va;

  logic [pgwalk_pkg::IDX_W-1:0]       idx;
  logic [pgwalk_pkg::WORD_W-1:0]      word;
  logic [pgwalk_pkg::WORD_W-1:0]      widx;
  logic                               oob;
  logic                               accept;
  logic                               descend;

  assign idx = (level == pgwalk_pkg::LEVEL_TOP) ? va[47:39] :
               (level == pgwalk_pkg::LEVEL_1G)  ? va[38:30] :
               (level == pgwalk_pkg::LEVEL_2M)  ? va[29:21] : va[20:12];
  assign word = {table_base, idx};
  assign oob  = word >= pgwalk_pkg::WORD_W'(TABLE_WORDS);
  assign widx = pgwalk_pkg::WORD_W'(req.word_index);

  // Outputs and per-state decisions
  always_comb begin
    req.ready = (state == pgwalk_pkg::ST_IDLE) && !clearing;
    accept    = req.valid && req.ready;
    wr_en     = accept && (req.opcode == pgwalk_pkg::OP_WRITE) &&
                (widx < pgwalk_pkg::WORD_W'(TABLE_WORDS));
    wr_addr   = widx[AW-1:0];
    wr_data   = req.entry_value;
    rd_en     = (state == pgwalk_pkg::ST_LOOKUP) && !oob;
    rd_addr   = word[AW-1:0];
    res_valid = 1'b0;
    descend   = 1'b0;
    res       = '0;
    res.fault_level = level;
    unique case (state)
      pgwalk_pkg::ST_LOOKUP: begin
        if (oob) begin
          res_valid      = 1'b1;
          res.fault_kind = pgwalk_pkg::FAULT_OUTSIDE;
        end
      end
      pgwalk_pkg::ST_CHECK: begin
        res_valid = 1'b1;
        priority if (!rd_data[pgwalk_pkg::BIT_PRESENT]) begin
          res.fault_kind = pgwalk_pkg::FAULT_NOT_PRESENT;
          res.leaf_entry = rd_data;
        end else if (!rd_data[pgwalk_pkg::BIT_USER]) begin
          res.fault_kind = pgwalk_pkg::FAULT_NOT_USER;
          res.leaf_entry = rd_data;
        end else if (level == pgwalk_pkg::LEVEL_1G && rd_data[pgwalk_pkg::BIT_SIZE]) begin
          res.mapped           = 1'b1;
          res.physical_address = {rd_data[51:30], va[29:0]};
          res.page_size_code   = pgwalk_pkg::PAGE_1G;
          res.leaf_entry       = rd_data;
        end else if (level == pgwalk_pkg::LEVEL_2M && rd_data[pgwalk_pkg::BIT_SIZE]) begin
          res.mapped           = 1'b1;
          res.physical_address = {rd_data[51:21], va[20:0]};
          res.page_size_code   = pgwalk_pkg::PAGE_2M;
          res.leaf_entry       = rd_data;
        end else if (level == pgwalk_pkg::LEVEL_LEAF) begin
          res.mapped           = 1'b1;
          res.physical_address = {rd_data[51:12], va[11:0]};
          res.page_size_code   = pgwalk_pkg::PAGE_4K;
          res.leaf_entry       = rd_data;
        end else begin
          res_valid = 1'b0;
          descend   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pgwalk_pkg::ST_IDLE: begin
        if (accept && req.opcode == pgwalk_pkg::OP_TRANSLATE) begin
          state_next = pgwalk_pkg::ST_LOOKUP;
        end
      end
      pgwalk_pkg::ST_LOOKUP: begin
        if (!oob) begin
          state_next = pgwalk_pkg::ST_CHECK;
        end else if (res_ready) begin
          state_next = pgwalk_pkg::ST_IDLE;
        end
      end
      pgwalk_pkg::ST_CHECK: begin
        if (descend) begin
          state_next = pgwalk_pkg::ST_LOOKUP;
        end else if (res_ready) begin
          state_next = pgwalk_pkg::ST_IDLE;
        end
      end
      default: state_next = pgwalk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgwalk_pkg::ST_IDLE;
      level <= pgwalk_pkg::LEVEL_TOP;
    end else begin
      state <= state_next;
      if (accept && req.opcode == pgwalk_pkg::OP_TRANSLATE) begin
        level <= pgwalk_pkg::LEVEL_TOP;
      end else if (state == pgwalk_pkg::ST_CHECK && descend) begin
        level <= level + 2'd1;
      end
    end
  end

  // Walk payload: address under translation and current table base
  always_ff @(posedge clk) begin
    if (accept && req.opcode == pgwalk_pkg::OP_TRANSLATE) begin
      va         <= req.virtual_address;
      table_base <= root[51:12];
    end else if (state == pgwalk_pkg::ST_CHECK && descend) begin
      table_base <= rd_data[51:12];
    end
  end

endmodule

### design/four_level_page_table_walker.sv
// Top level of the four-level page-table walker: store, walker, output register.
// Depends on pgwalk_pkg, the channel interfaces, pgwalk_store and pgwalk_walker.
//
// Translates 48-bit virtual addresses through four levels of x86-64 style page
// tables kept in a local store of TABLE_WORDS 64-bit words. A write word with
// opcode 0 loads one table word and returns nothing; a write beyond the store
// is dropped. A translate word with opcode 1 walks from the root register and
// returns one response word: the mapped physical address, page size, leaf
// entry, and on failure the fault kind and level. Each level that is read
// passes through two states, a lookup state that issues the store read and a
// check state that tests the entry, because every level's table address comes
// from the entry read before it. A walk ends at the level whose entry maps a
// 1 GiB, 2 MiB or 4 KiB page, or early at the level whose entry is missing or
// non-user or whose table lies outside the store. The store has a single read
// port. The response sits in an output register, so the next request word is
// taken while a response waits. After reset the store is zeroed by a sweep
// through all TABLE_WORDS words, during which no request word is taken; the
// root register can be written at any time the block is idle, including
// during the sweep.
module four_level_page_table_walker #(
  parameter int TABLE_WORDS = 4096
) (
  input  logic          clk,
  input  logic          rst,
  pgwalk_req_if.sink    req,
  pgwalk_rsp_if.source  rsp,
  pgwalk_cfg_if.sink    cfg
);

  localparam int AW = $clog2(TABLE_WORDS);

  logic [pgwalk_pkg::PA_W-1:0]     root;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  logic [pgwalk_pkg::ENTRY_W-1:0]  wr_data;
  logic                            rd_en;
  logic [AW-1:0]                   rd_addr;
  logic [pgwalk_pkg::ENTRY_W-1:0]  rd_data;
  logic                            clearing;
  logic                            res_valid;
  logic                            res_ready;
  pgwalk_pkg::walk_result_t        res;
  logic                            out_valid;
  pgwalk_pkg::walk_result_t        out_res;

  // Root register: always ready, low 12 bits ignored by the walker
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (cfg.valid) begin
      root <= cfg.root_table_address;
    end
  end

  pgwalk_store #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  // Writes happen only while idle and reads only mid-walk, so the store
  // never sees a read and a write to the same word in one cycle.
  pgwalk_walker #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .root      (root),
    .clearing  (clearing),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or draining, hold while stalled
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.mapped           = out_res.mapped;
  assign rsp.physical_address = out_res.physical_address;
  assign rsp.page_size_code   = out_res.page_size_code;
  assign rsp.leaf_entry       = out_res.leaf_entry;
  assign rsp.fault_kind       = out_res.fault_kind;
  assign rsp.fault_level      = out_res.fault_level;

`ifndef SYNTHESIS
  // No request word may be taken while the clear sweep runs
  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("request taken during store clear");

  // A mapped response carries no fault and a leaf below the top level
  a_mapped_consistent: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.mapped |->
      rsp.fault_kind == pgwalk_pkg::FAULT_NONE &&
      rsp.fault_level != pgwalk_pkg::LEVEL_TOP)
    else $error("mapped response with fault or top-level leaf");

  // A faulting response carries a fault kind and zero address and size
  a_fault_consistent: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.mapped |->
      rsp.fault_kind != pgwalk_pkg::FAULT_NONE &&
      rsp.physical_address == '0 &&
      rsp.page_size_code == pgwalk_pkg::PAGE_4K)
    else $error("unmapped response without fault or with address");

  // The store is read only while no write is in flight
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !wr_en)
    else $error("store read and write in the same cycle");
`endif

endmodule
